@@ rtl/core/i2cbm_pkg.sv @@
// i2cbm_pkg: shared types and constants for the i2c register burst master
// used by every module under rtl/core but i2cbm_props; depends on nothing
package i2cbm_pkg;

  // command codes carried in s_tuser
  typedef enum logic [1:0] {
    OP_SLOT  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // configuration reset values
  localparam logic [7:0] DEV_ADDR_RESET    = 8'h64;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // sequencer phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_START   = 9'b000000010,
    PH_RESTART = 9'b000000100,
    PH_DEV     = 9'b000001000,
    PH_REG     = 9'b000010000,
    PH_DATA    = 9'b000100000,
    PH_DEVR    = 9'b001000000,
    PH_RECV    = 9'b010000000,
    PH_STOP    = 9'b100000000
  } phase_t;

  // sequencer state
  typedef struct packed {
    phase_t     phase;
    logic [1:0] slot_in_bit;
    logic [3:0] bit_index;
    logic [7:0] shift_reg;
    logic [7:0] bytes_left;
    logic [7:0] ack_wait_count;
    logic [7:0] latched_register;
    logic       is_read;
    logic       outcome_ok;
  } seq_state_t;

  // configuration values seen by the sequencer
  typedef struct packed {
    logic [7:0] device_write_address;
    logic [7:0] ack_timeout;
  } cfg_t;

  // one result item, first field in the highest bit when packed
  typedef struct packed {
    logic       success;
    logic       done_res;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       data_request;
    logic       sda_enable;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

@@ rtl/core/i2cbm_cfg.sv @@
// i2cbm_cfg: configuration registers (device address, ack timeout)
// depends on i2cbm_pkg
module i2cbm_cfg import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_write_address <= DEV_ADDR_RESET;
      cfg.ack_timeout          <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:    cfg.device_write_address <= cfg_data;
        CFG_ACK_TIMEOUT: cfg.ack_timeout          <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/i2cbm_step.sv @@
// i2cbm_step: next-state and result logic for one bus time slot
// depends on i2cbm_pkg
module i2cbm_step import i2cbm_pkg::*; (
  input  seq_state_t st,
  input  cfg_t       cfg,
  input  logic [1:0] operation,
  input  logic [7:0] register_address,
  input  logic [7:0] byte_count,
  input  logic [7:0] write_byte,
  input  logic       sda_sample,
  output seq_state_t st_next,
  output result_t    res
);

  seq_state_t n;
  logic       scl;
  logic       sda;
  logic       en;
  logic       req;
  logic [7:0] dec;

  always_comb begin
    n   = st;
    scl = 1'b1;
    sda = 1'b1;
    en  = 1'b0;
    req = 1'b0;
    dec = 8'd0;
    res = '0;
    res.busy_res = 1'b1;

    // command start from idle
    if (st.phase == PH_IDLE && (operation == OP_WRITE || operation == OP_READ)) begin
      n.is_read          = (operation == OP_READ);
      n.latched_register = register_address;
      n.bytes_left       = (operation == OP_READ && byte_count == 8'd0) ? 8'd1 : byte_count;
      n.outcome_ok       = 1'b1;
      n.ack_wait_count   = 8'd0;
      n.bit_index        = 4'd0;
      n.phase            = PH_START;
      n.slot_in_bit      = 2'd1;
    end

    unique case (n.phase)
      // start and repeated start
      PH_START, PH_RESTART: begin
        en = 1'b1;
        if (n.slot_in_bit == 2'd0) begin
          scl = 1'b0;
          n.slot_in_bit = 2'd1;
        end else if (n.slot_in_bit == 2'd1) begin
          n.slot_in_bit = 2'd2;
        end else begin
          sda = 1'b0;
          n.slot_in_bit = 2'd0;
          n.bit_index   = 4'd0;
          if (n.phase == PH_START) begin
            n.shift_reg = cfg.device_write_address;
            n.phase     = PH_DEV;
          end else begin
            n.shift_reg = cfg.device_write_address | 8'd1;
            n.phase     = PH_DEVR;
          end
        end
      end

      // byte transmit and ack wait
      PH_DEV, PH_REG, PH_DATA, PH_DEVR: begin
        if (n.bit_index < BITS_PER_BYTE) begin
          if (n.phase == PH_DATA && n.bit_index == 4'd0 && n.slot_in_bit == 2'd0) begin
            n.shift_reg = write_byte;
          end
          en  = 1'b1;
          sda = n.shift_reg[7];
          if (n.slot_in_bit == 2'd0) begin
            scl = 1'b0;
            n.slot_in_bit = 2'd1;
          end else begin
            n.slot_in_bit = 2'd0;
            n.shift_reg   = {n.shift_reg[6:0], 1'b0};
            n.bit_index   = n.bit_index + 4'd1;
            if (n.bit_index == BITS_PER_BYTE) begin
              n.ack_wait_count = 8'd0;
            end
          end
        end else if (n.slot_in_bit == 2'd0) begin
          scl = 1'b0;
          n.slot_in_bit = 2'd1;
        end else if (!sda_sample) begin
          // acked: pick the next byte
          n.slot_in_bit = 2'd0;
          n.bit_index   = 4'd0;
          if (n.phase == PH_DEV) begin
            n.shift_reg = n.latched_register;
            n.phase     = PH_REG;
          end else if (n.phase == PH_REG) begin
            if (n.is_read) begin
              n.phase = PH_RESTART;
            end else if (n.bytes_left != 8'd0) begin
              req     = 1'b1;
              n.phase = PH_DATA;
            end else begin
              n.phase = PH_STOP;
            end
          end else if (n.phase == PH_DATA) begin
            dec = (n.bytes_left != 8'd0) ? n.bytes_left - 8'd1 : 8'd0;
            n.bytes_left = dec;
            if (dec != 8'd0) begin
              req     = 1'b1;
              n.phase = PH_DATA;
            end else begin
              n.phase = PH_STOP;
            end
          end else begin
            n.phase = PH_RECV;
          end
        end else if (n.ack_wait_count >= cfg.ack_timeout) begin
          n.outcome_ok  = 1'b0;
          n.phase       = PH_STOP;
          n.slot_in_bit = 2'd0;
          n.bit_index   = 4'd0;
        end else begin
          n.ack_wait_count = n.ack_wait_count + 8'd1;
        end
      end

      // byte receive and master ack/nack
      PH_RECV: begin
        if (n.bit_index < BITS_PER_BYTE) begin
          if (n.slot_in_bit == 2'd0) begin
            scl = 1'b0;
            n.slot_in_bit = 2'd1;
          end else begin
            n.slot_in_bit = 2'd0;
            n.shift_reg   = {n.shift_reg[6:0], sda_sample};
            n.bit_index   = n.bit_index + 4'd1;
            if (n.bit_index == BITS_PER_BYTE) begin
              res.read_valid = 1'b1;
              res.read_byte  = n.shift_reg;
            end
          end
        end else begin
          en  = 1'b1;
          sda = (n.bytes_left <= 8'd1);
          if (n.slot_in_bit == 2'd0) begin
            scl = 1'b0;
            n.slot_in_bit = 2'd1;
          end else begin
            dec = (n.bytes_left != 8'd0) ? n.bytes_left - 8'd1 : 8'd0;
            n.bytes_left  = dec;
            n.phase       = (dec != 8'd0) ? PH_RECV : PH_STOP;
            n.slot_in_bit = 2'd0;
            n.bit_index   = 4'd0;
          end
        end
      end

      // stop condition
      PH_STOP: begin
        en = 1'b1;
        if (n.slot_in_bit == 2'd0) begin
          scl = 1'b0;
          sda = 1'b0;
          n.slot_in_bit = 2'd1;
        end else if (n.slot_in_bit == 2'd1) begin
          sda = 1'b0;
          n.slot_in_bit = 2'd2;
        end else begin
          res.done_res  = 1'b1;
          res.success   = n.outcome_ok;
          n.phase       = PH_IDLE;
          n.slot_in_bit = 2'd0;
          n.bit_index   = 4'd0;
        end
      end

      // idle and any stray code
      default: begin
        n.phase       = PH_IDLE;
        n.slot_in_bit = 2'd0;
        n.bit_index   = 4'd0;
        res.busy_res  = 1'b0;
      end
    endcase

    res.scl_level    = scl;
    res.sda_level    = en ? sda : 1'b1;
    res.sda_enable   = en;
    res.data_request = req;
    st_next = n;
  end

endmodule

@@ rtl/core/i2c_register_burst_master.sv @@
// Tick-driven I2C register master. Each input item is one bus time slot and
// gives exactly one result item with the SCL/SDA drive for that slot. An item
// is taken only when ready: the sequencer state and the result register update
// together at acceptance, and the input stays ready while the result register
// is empty or being drained, so the rate is one item per clock whenever the
// output side keeps up. Writes: start, device address, register address, then
// byte_count data bytes, each asked for with data_request and taken from the
// following item's write_byte. Reads: repeated start, read address, byte_count
// bytes (zero counts as one), last byte nacked. An ack timeout ends with one
// stop and success low. The user must write configuration only while idle;
// the block does not enforce it; depends on i2cbm_pkg, i2cbm_cfg, i2cbm_step
module i2c_register_burst_master import i2cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // slot items in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // register_address, byte_count, write_byte, sda_sample, zero pad
  input  logic [1:0]  s_tuser,  // operation
  // result items out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // scl_level, sda_level, sda_enable, data_request,
                                // read_byte, read_valid, busy_res, done_res, success
);

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  result_t    res;
  result_t    res_reg;
  logic       accept;

  i2cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cbm_step u_step (
    .st               (st),
    .cfg              (cfg),
    .operation        (s_tuser),
    .register_address (s_tdata[7:0]),
    .byte_count       (s_tdata[15:8]),
    .write_byte       (s_tdata[23:16]),
    .sda_sample       (s_tdata[24]),
    .st_next          (st_next),
    .res              (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= PH_IDLE;
      st.slot_in_bit      <= 2'd0;
      st.bit_index        <= 4'd0;
      st.shift_reg        <= 8'd0;
      st.bytes_left       <= 8'd0;
      st.ack_wait_count   <= 8'd0;
      st.latched_register <= 8'd0;
      st.is_read          <= 1'b0;
      st.outcome_ok       <= 1'b1;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg <= res;
    end
  end

  assign m_tdata = res_reg;

endmodule

@@ rtl/core/i2cbm_checker.sv @@
// i2cbm_props: port-level assertions for the i2c register burst master
// bound to i2c_register_burst_master; depends on nothing else
module i2cbm_props (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // done only inside a transaction
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> m_tdata[13])
    else $error("done without busy");

  // success only with done
  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> m_tdata[14])
    else $error("success without done");

  // a read byte completes on a high clock with the line released
  a_rvalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[0] && !m_tdata[2])
    else $error("read byte outside a released high clock slot");

  // released line reads as high
  a_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1])
    else $error("sda level low while released");

endmodule

bind i2c_register_burst_master i2cbm_props u_i2cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/i2cbm_checker.sv @@
`timescale 1ns / 100ps
// i2cbm_checker: watches the config port and both item channels of the i2c register
// burst master, predicts every result item and compares it; depends on i2cbm_pkg
module i2cbm_checker import i2cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // register_address, byte_count, write_byte, sda_sample, zero pad
  input  logic [1:0]  s_tuser,   // operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // scl_level, sda_level, sda_enable, data_request,
                                 // read_byte, read_valid, busy_res, done_res, success
  output int unsigned n_predicted,
  output int unsigned n_checked,
  output int unsigned mismatches,
  output logic        bus_idle
);

  // predicted sequencer state and configuration
  phase_t     ph;
  logic [1:0] sib;
  logic [3:0] bidx;
  logic [7:0] shreg;
  logic [7:0] left;
  logic [7:0] waitc;
  logic [7:0] reg_l;
  logic       rd;
  logic       ok_l;
  logic [7:0] dev_addr;
  logic [7:0] ack_lim;

  result_t bus_results_q[$];
  result_t want;
  result_t got;

  task automatic report_mismatch(input string what, input logic [7:0] g, input logic [7:0] w);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, g, w);
  endtask

  task automatic check_field(input string what, input logic [7:0] g, input logic [7:0] w);
    if (g !== w) report_mismatch(what, g, w);
  endtask

  task automatic goto_byte(input phase_t p);
    ph = p;
    sib = 2'd0;
    bidx = 4'd0;
  endtask

  // acked byte: pick what follows, return a data request
  task automatic take_ack(output logic req);
    req = 1'b0;
    case (ph)
      PH_DEV: begin
        shreg = reg_l;
        goto_byte(PH_REG);
      end
      PH_REG: begin
        if (rd) goto_byte(PH_RESTART);
        else if (left != 8'd0) begin
          req = 1'b1;
          goto_byte(PH_DATA);
        end else goto_byte(PH_STOP);
      end
      PH_DATA: begin
        if (left != 8'd0) left--;
        if (left != 8'd0) begin
          req = 1'b1;
          goto_byte(PH_DATA);
        end else goto_byte(PH_STOP);
      end
      default: goto_byte(PH_RECV);
    endcase
  endtask

  // one bus slot: advance the predicted sequencer and build the result item
  task automatic predict_slot(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] cnt,
                              input logic [7:0] wb, input logic sda_in, output result_t r);
    logic scl, sda_o, drive, req, rvalid, busy, done, okv;
    logic [7:0] rbyte;
    scl = 1'b1; sda_o = 1'b1; drive = 1'b0; req = 1'b0; rvalid = 1'b0;
    busy = 1'b1; done = 1'b0; okv = 1'b0; rbyte = 8'd0;

    // command latched only while idle
    if (ph == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
      rd = (op == OP_READ);
      reg_l = ra;
      left = (rd && cnt == 8'd0) ? 8'd1 : cnt;
      ok_l = 1'b1;
      waitc = 8'd0;
      bidx = 4'd0;
      ph = PH_START;
      sib = 2'd1;
    end

    case (ph)
      PH_START, PH_RESTART: begin
        drive = 1'b1;
        if (sib == 2'd0) begin
          scl = 1'b0; sda_o = 1'b1; sib = 2'd1;
        end else if (sib == 2'd1) begin
          scl = 1'b1; sda_o = 1'b1; sib = 2'd2;
        end else begin
          scl = 1'b1; sda_o = 1'b0;
          if (ph == PH_START) begin
            shreg = dev_addr;
            goto_byte(PH_DEV);
          end else begin
            shreg = dev_addr | 8'd1;
            goto_byte(PH_DEVR);
          end
        end
      end
      PH_DEV, PH_REG, PH_DATA, PH_DEVR: begin
        if (bidx < BITS_PER_BYTE) begin
          if (ph == PH_DATA && bidx == 4'd0 && sib == 2'd0) shreg = wb;
          drive = 1'b1;
          sda_o = shreg[7];
          if (sib == 2'd0) begin
            scl = 1'b0; sib = 2'd1;
          end else begin
            scl = 1'b1;
            sib = 2'd0;
            shreg = shreg << 1;
            bidx++;
            if (bidx == BITS_PER_BYTE) waitc = 8'd0;
          end
        end else if (sib == 2'd0) begin
          scl = 1'b0; sib = 2'd1;
        end else begin
          // ack sample slot repeats until sda low or timeout
          scl = 1'b1;
          if (!sda_in) take_ack(req);
          else if (waitc >= ack_lim) begin
            ok_l = 1'b0;
            goto_byte(PH_STOP);
          end else waitc++;
        end
      end
      PH_RECV: begin
        if (bidx < BITS_PER_BYTE) begin
          if (sib == 2'd0) begin
            scl = 1'b0; sib = 2'd1;
          end else begin
            scl = 1'b1;
            sib = 2'd0;
            shreg = {shreg[6:0], sda_in};
            bidx++;
            if (bidx == BITS_PER_BYTE) begin
              rvalid = 1'b1;
              rbyte = shreg;
            end
          end
        end else begin
          // master ack, nack on the last byte
          drive = 1'b1;
          sda_o = (left <= 8'd1);
          if (sib == 2'd0) begin
            scl = 1'b0; sib = 2'd1;
          end else begin
            scl = 1'b1;
            if (left != 8'd0) left--;
            goto_byte(left != 8'd0 ? PH_RECV : PH_STOP);
          end
        end
      end
      PH_STOP: begin
        drive = 1'b1;
        if (sib == 2'd0) begin
          scl = 1'b0; sda_o = 1'b0; sib = 2'd1;
        end else if (sib == 2'd1) begin
          scl = 1'b1; sda_o = 1'b0; sib = 2'd2;
        end else begin
          scl = 1'b1; sda_o = 1'b1;
          done = 1'b1;
          okv = ok_l;
          goto_byte(PH_IDLE);
        end
      end
      default: begin
        goto_byte(PH_IDLE);
        busy = 1'b0;
      end
    endcase

    r.scl_level    = scl;
    r.sda_level    = drive ? sda_o : 1'b1;
    r.sda_enable   = drive;
    r.data_request = req;
    r.read_byte    = rbyte;
    r.read_valid   = rvalid;
    r.busy_res     = busy;
    r.done_res     = done;
    r.success      = okv;
  endtask

  // predict on accepted input items, compare on accepted result items
  always @(posedge clk) begin
    if (rst) begin
      ph = PH_IDLE; sib = 2'd0; bidx = 4'd0; shreg = 8'd0; left = 8'd0;
      waitc = 8'd0; reg_l = 8'd0; rd = 1'b0; ok_l = 1'b1;
      dev_addr = DEV_ADDR_RESET;
      ack_lim = ACK_TIMEOUT_RESET;
      bus_results_q.delete();
      n_predicted <= 0;
      n_checked <= 0;
      bus_idle <= 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEV_ADDR) dev_addr = cfg_data;
        else ack_lim = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        predict_slot(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[24], want);
        bus_results_q.push_back(want);
        n_predicted <= n_predicted + 1;
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (bus_results_q.size() == 0) begin
          report_mismatch("result item with nothing pending", got[7:0], 8'd0);
        end else begin
          want = bus_results_q.pop_front();
          check_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
          check_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
          check_field("sda_enable", 8'(got.sda_enable), 8'(want.sda_enable));
          check_field("data_request", 8'(got.data_request), 8'(want.data_request));
          check_field("read_byte", got.read_byte, want.read_byte);
          check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
          check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(got.done_res), 8'(want.done_res));
          check_field("success", 8'(got.success), 8'(want.success));
        end
        n_checked <= n_checked + 1;
      end
      bus_idle <= (ph == PH_IDLE);
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives slot items and config writes into the i2c register burst master
// and gives the verdict; depends on i2cbm_pkg, i2cbm_checker and the rtl top
module testbench;
  import i2cbm_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DEV_ADDR;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;   // register_address, byte_count, write_byte, sda_sample, zero pad
  logic [1:0]  s_tuser = OP_SLOT; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // scl_level, sda_level, sda_enable, data_request,
                                  // read_byte, read_valid, busy_res, done_res, success

  int unsigned n_predicted;
  int unsigned n_checked;
  int unsigned mismatches;
  logic        bus_idle;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        recv_press = 1'b0;
  int          since_cmd = 0;
  int unsigned quiet_cycles = 0;

  always #6 clk = ~clk;

  i2c_register_burst_master uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  i2cbm_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .n_predicted(n_predicted),
    .n_checked  (n_checked),
    .mismatches (mismatches),
    .bus_idle   (bus_idle)
  );

  // receiver: random stalls, or long hold-offs so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (recv_press) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        m_tready <= 1'b1;
        repeat (150) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // offer one slot item, with random sender gaps, and wait for acceptance
  task automatic send_slot(input op_t op, input logic [7:0] ra, input logic [7:0] cnt,
                           input logic [7:0] wb, input logic sda);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, sda, wb, cnt, ra};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE || op == OP_READ) since_cmd = 0;
    else since_cmd++;
  endtask

  // random slot item; commands carry small byte counts
  task automatic random_slot(input int sda_pct, input bit cmds, input int wb_sel);
    int unsigned pick;
    op_t op;
    logic [7:0] cnt;
    logic [7:0] wb;
    pick = $urandom_range(0, 99);
    op = OP_SLOT;
    if (cmds && pick < 7) op = OP_WRITE;
    else if (cmds && pick < 14) op = OP_READ;
    else if (pick >= 96) op = OP_NONE;
    if (op == OP_WRITE || op == OP_READ)
      cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 12)) : 8'($urandom_range(0, 3));
    else
      cnt = 8'($urandom_range(0, 255));
    wb = (wb_sel < 0) ? 8'($urandom_range(0, 255)) : 8'(wb_sel);
    send_slot(op, 8'($urandom_range(0, 255)), cnt, wb, $urandom_range(0, 99) < sda_pct);
  endtask

  // run plain slots until the bus is idle, then drain all results
  task automatic settle(input int sda_pct, input int wb_sel);
    do random_slot(sda_pct, 1'b0, wb_sel);
    while (!(since_cmd >= 2 && bus_idle));
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_predicted != n_checked) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic burst(input op_t op, input logic [7:0] ra, input logic [7:0] cnt,
                       input int sda_pct, input int wb_sel);
    send_slot(op, ra, cnt, 8'($urandom_range(0, 255)), 1'b0);
    settle(sda_pct, wb_sel);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [7:0] lim);
    write_cfg(CFG_DEV_ADDR, dev);
    write_cfg(CFG_ACK_TIMEOUT, lim);
  endtask

  initial begin : stimulus
    logic [7:0] dev;
    logic [7:0] lim;
    int sda_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset configuration
    burst(OP_WRITE, 8'hFF, 8'd2, 0, 8'hFF);
    burst(OP_WRITE, 8'h00, 8'd1, 20, 8'h00);
    // zero byte write stops after the register ack
    burst(OP_WRITE, 8'h5A, 8'd0, 20, -1);
    // zero byte read still reads one byte
    burst(OP_READ, 8'h33, 8'd0, 40, -1);
    burst(OP_READ, 8'hAA, 8'd3, 50, -1);
    // unused op code at idle acts as a plain slot
    send_slot(OP_NONE, 8'h12, 8'd4, 8'h00, 1'b0);
    settle(30, -1);
    // a command while busy is ignored
    send_slot(OP_WRITE, 8'h21, 8'd2, 8'h00, 1'b0);
    repeat (6) random_slot(0, 1'b0, -1);
    send_slot(OP_READ, 8'hC3, 8'd5, 8'h00, 1'b0);
    settle(10, -1);
    // short ack timeout, then device address never acked
    set_config(8'h00, 8'd1);
    burst(OP_READ, 8'h01, 8'd1, 60, -1);
    burst(OP_WRITE, 8'h80, 8'd255, 100, -1);
    burst(OP_READ, 8'h7F, 8'd255, 100, -1);
    // address with bit0 set, timeout of zero fails on first high sample
    set_config(8'hFF, 8'd0);
    burst(OP_WRITE, 8'hF0, 8'd1, 30, -1);
    burst(OP_READ, 8'h0F, 8'd2, 30, -1);

    // random phases over settings and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dev = 8'h64; lim = 8'd250; sda_pct = 25; end
        1: begin dev = 8'h00; lim = 8'd3;   sda_pct = 55; end
        2: begin dev = 8'hFE; lim = 8'd255; sda_pct = 20; end
        3: begin dev = 8'($urandom_range(0, 255)); lim = 8'd1; sda_pct = 60; end
        4: begin dev = 8'hFF; lim = 8'd8;   sda_pct = 35; end
        5: begin dev = 8'($urandom_range(0, 255)); lim = 8'd255; sda_pct = 30; end
        6: begin dev = 8'h01; lim = 8'd2;   sda_pct = 65; end
        default: begin
          dev = 8'($urandom_range(0, 255));
          lim = 8'($urandom_range(1, 255));
          sda_pct = 25;
        end
      endcase
      set_config(dev, lim);
      case (p)
        1: begin send_idle_pct = 50; recv_stall_pct <= 0;  recv_press <= 1'b0; end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 50; recv_press <= 1'b0; end
        3, 6: begin send_idle_pct = 32; recv_stall_pct <= 32; recv_press <= 1'b0; end
        4: begin send_idle_pct = 0;  recv_stall_pct <= 0;  recv_press <= 1'b1; end
        7: begin send_idle_pct = 0;  recv_stall_pct <= 50; recv_press <= 1'b0; end
        default: begin send_idle_pct = 0; recv_stall_pct <= 0; recv_press <= 1'b0; end
      endcase
      repeat (PHASE_ITEMS) random_slot(sda_pct, 1'b1, -1);
      settle(sda_pct, -1);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
